FILE: rtl/hamming_sec_encode_decode_macros.svh
// Assertion macros for the Hamming single-error-correcting encoder/decoder.
// Used by the top level only; every macro samples on clk and is disabled in reset.
`ifndef HAMMING_SEC_ENCODE_DECODE_MACROS_SVH
`define HAMMING_SEC_ENCODE_DECODE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HSEC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HSEC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/hsec_pkg.sv
// Shared types, codes and helper functions for the Hamming SEC encoder/decoder.
// No dependencies; imported by every module of the block.
package hsec_pkg;

    localparam int WORD_W = 38;   // code_word and word_in field width
    localparam int POS_W  = 6;    // syndrome, position and data width fields
    localparam int R_W    = 3;    // parity count
    localparam int POS_MAX = 64;  // widest position space the syndrome can name

    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAN     = 2'd0,
        ST_CORRECTED = 2'd1,
        ST_BEYOND    = 2'd2
    } hsec_status_t;

    typedef struct packed {
        logic              command;
        logic [WORD_W-1:0] word_in;
    } hsec_req_t;

    typedef struct packed {
        logic [WORD_W-1:0] code_word;
        logic [POS_W-1:0]  error_position;
        hsec_status_t      status;
    } hsec_rsp_t;

    // Derived code geometry for the current data width.
    typedef struct packed {
        logic [POS_W-1:0] m;
        logic [R_W-1:0]   r;
        logic [POS_W-1:0] n;
    } hsec_cfg_t;

    // Least r with 2^r >= m + r + 1.
    function automatic int hsec_parity_count(int m);
        int r;
        r = 0;
        while (r < 7 && ((1 << r) < m + r + 1)) begin
            r = r + 1;
        end
        return r;
    endfunction

    // Bit i is set when position i+1 has bit p of its index set.
    function automatic logic [POS_MAX-1:0] hsec_cover(int p);
        logic [POS_MAX-1:0] mask;
        mask = '0;
        for (int i = 0; i < POS_MAX; i++) begin
            mask[i] = (((i + 1) >> p) & 1) != 0;
        end
        return mask;
    endfunction

endpackage

FILE: rtl/hamming_sec_encode_decode.sv
// Hamming single-error-correcting encoder/decoder: top level with the input
// and result registers. Depends on hsec_pkg, hsec_cfg, hsec_core and the macros header.
//
// Usage:
//   req channel (req_valid / req_stall / req) carries one command per beat:
//   encode a data word of m bits, or check and correct an n-bit code word.
//   rsp channel (rsp_valid / rsp_stall / rsp) returns one result beat per
//   request, in order: code word, syndrome and status.
//   cfg channel (cfg_valid / cfg_ready / cfg_data) sets the data width m;
//   0 reads as 1 and values above MAX_DATA_BITS saturate. Write it only while
//   the block is idle. cfg_ready is always high.
// Pipeline: an accepted request is held in the input register and its result
// is then registered in the result register, which drives rsp. Throughput: one
// beat per cycle while rsp_stall is low, set by the single parity and syndrome
// XOR stage between the input register and the result register.
// Stall: a stalled result holds in the result register; the input register
// still takes one more beat, and req_stall rises only when both are full
// and rsp_stall is high.
// Reset: both pipeline stages empty, data width 4.
`include "hamming_sec_encode_decode_macros.svh"

module hamming_sec_encode_decode
    import hsec_pkg::*;
#(
    parameter int MAX_DATA_BITS = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  hsec_req_t        req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output hsec_rsp_t        rsp,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [POS_W-1:0] cfg_data
);

    hsec_cfg_t geom;
    hsec_req_t s1_item_reg;
    logic      s1_valid_reg;
    logic      s1_valid_next;
    hsec_rsp_t rsp_reg;
    logic      rsp_valid_reg;
    logic      rsp_valid_next;
    hsec_rsp_t core_rsp;
    logic      s2_load;
    logic      s1_load;

    hsec_cfg #(
        .MAX_DATA_BITS(MAX_DATA_BITS)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .geom     (geom)
    );

    hsec_core #(
        .MAX_DATA_BITS(MAX_DATA_BITS)
    ) u_core (
        .req (s1_item_reg),
        .geom(geom),
        .rsp (core_rsp)
    );

    assign s2_load   = !rsp_valid_reg || !rsp_stall;
    assign s1_load   = !s1_valid_reg || s2_load;
    assign req_stall = !s1_load;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        rsp_valid_next = rsp_valid_reg;
        if (s1_load) begin
            s1_valid_next = req_valid;
        end
        if (s2_load) begin
            rsp_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && req_valid) begin
            s1_item_reg <= req;
        end
        if (s2_load && s1_valid_reg) begin
            rsp_reg <= core_rsp;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `HSEC_ASSERT_SAME(a_no_overrun, rsp_valid && rsp_stall && s1_valid_reg, req_stall,
        "input register would be overwritten while the result is stalled")
    `HSEC_ASSERT_NEXT(a_accept_fills, req_valid && !req_stall, s1_valid_reg,
        "accepted beat did not reach the input register")
    `HSEC_ASSERT_SAME(a_corrected_pos, rsp_valid && rsp.status == ST_CORRECTED,
        rsp.error_position != '0 && rsp.error_position <= geom.n,
        "corrected beat reports a position outside the code word")
    `HSEC_ASSERT_SAME(a_width_range, 1'b1,
        geom.m != '0 && geom.m <= POS_W'(MAX_DATA_BITS) && geom.n > geom.m,
        "data width register left its legal range")

endmodule

FILE: rtl/hsec_cfg.sv
// Data width register with the derived code geometry (m, r, n).
// Depends on hsec_pkg.
module hsec_cfg
    import hsec_pkg::*;
#(
    parameter int MAX_DATA_BITS = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [POS_W-1:0] cfg_data,
    output hsec_cfg_t        geom
);

    localparam int M_RST = (MAX_DATA_BITS < 4) ? MAX_DATA_BITS : 4;
    localparam int R_RST = hsec_parity_count(M_RST);

    hsec_cfg_t geom_reg;
    hsec_cfg_t geom_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        logic [POS_W-1:0] m;
        logic [R_W-1:0]   r;
        if (cfg_data == '0) begin
            m = POS_W'(1);
        end else if (cfg_data > POS_W'(MAX_DATA_BITS)) begin
            m = POS_W'(MAX_DATA_BITS);
        end else begin
            m = cfg_data;
        end
        r = R_W'(hsec_parity_count(int'(m)));
        geom_next.m = m;
        geom_next.r = r;
        geom_next.n = m + POS_W'(r);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            geom_reg.m <= POS_W'(M_RST);
            geom_reg.r <= R_W'(R_RST);
            geom_reg.n <= POS_W'(M_RST + R_RST);
        end else if (cfg_valid && cfg_ready) begin
            geom_reg <= geom_next;
        end
    end

    assign geom = geom_reg;

endmodule

FILE: rtl/hsec_core.sv
// Combinational Hamming encode and syndrome/correct datapath for one beat.
// Depends on hsec_pkg; geometry comes from hsec_cfg.
module hsec_core
    import hsec_pkg::*;
#(
    parameter int MAX_DATA_BITS = 32
)
(
    input  hsec_req_t req,
    input  hsec_cfg_t geom,
    output hsec_rsp_t rsp
);

    localparam int CW = MAX_DATA_BITS + hsec_parity_count(MAX_DATA_BITS);

    logic [CW-1:0]    data_spread;
    logic [CW-1:0]    parity_bits;
    logic [CW-1:0]    recv;
    logic [CW-1:0]    flip;
    logic [CW-1:0]    code;
    logic [POS_W-1:0] syn;
    logic             in_range;

    // Scatter data bits onto the non-power-of-two positions and mask the
    // received word to n bits.
    for (genvar i = 0; i < CW; i++) begin : g_pos
        localparam int POS    = i + 1;
        localparam bit IS_PAR = (POS & (POS - 1)) == 0;
        localparam int K      = POS - 1 - $clog2(POS + 1);

        if (IS_PAR || K >= WORD_W) begin : g_none
            assign data_spread[i] = 1'b0;
        end else begin : g_data
            assign data_spread[i] = req.word_in[K] & (POS_W'(K) < geom.m);
        end

        if (i < WORD_W) begin : g_rx
            assign recv[i] = req.word_in[i] & (POS_W'(i) < geom.n);
        end else begin : g_rx_none
            assign recv[i] = 1'b0;
        end

        assign flip[i] = in_range && (syn == POS_W'(POS));
    end

    for (genvar p = 0; p < POS_W; p++) begin : g_par
        localparam logic [POS_MAX-1:0] COV = hsec_cover(p);

        assign syn[p] = ^(recv & COV[CW-1:0]);

        if ((1 << p) <= CW) begin : g_enc
            assign parity_bits[(1 << p) - 1] =
                (^(data_spread & COV[CW-1:0])) & (R_W'(p) < geom.r);
        end
    end

    // Non-parity positions of parity_bits are zero.
    for (genvar i = 0; i < CW; i++) begin : g_fill
        if (((i + 1) & i) != 0) begin : g_zero
            assign parity_bits[i] = 1'b0;
        end
    end

    assign in_range = (syn != '0) && (syn <= geom.n);

    always_comb
    begin
        if (req.command == CMD_ENCODE) begin
            code               = data_spread | parity_bits;
            rsp.error_position = '0;
            rsp.status         = ST_CLEAN;
        end else begin
            code               = recv ^ flip;
            rsp.error_position = syn;
            if (syn == '0) begin
                rsp.status = ST_CLEAN;
            end else if (in_range) begin
                rsp.status = ST_CORRECTED;
            end else begin
                rsp.status = ST_BEYOND;
            end
        end
        rsp.code_word = WORD_W'(code);
    end

endmodule

FILE: test/tb.sv
// Self-checking testbench for the Hamming single-error-correcting encoder/decoder.
// Depends on hsec_pkg and the hamming_sec_encode_decode top level; no other files.
`timescale 1ns / 1ps

module tb;
    import hsec_pkg::*;

    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 153;
    localparam int DRAIN_CYCLES = 4;

    logic             clk;
    logic             rst_n     = 1'b0;
    logic             req_valid = 1'b0;
    logic             req_stall;
    hsec_req_t        req       = '0;
    logic             rsp_valid;
    logic             rsp_stall = 1'b0;
    hsec_rsp_t        rsp;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [POS_W-1:0] cfg_data  = '0;

    hsec_req_t        req_backlog[$];
    hsec_rsp_t        due_results[$];
    logic [POS_W-1:0] cur_width   = 6'd4;
    bit               quiet_phase = 1'b0;
    int               fail_count  = 0;
    int               checked     = 0;
    int               corrected   = 0;
    int               beyond      = 0;
    int               gap_left    = 0;
    int               stall_left  = 0;

    hamming_sec_encode_decode DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int eff_width(input logic [POS_W-1:0] width);
        int m;
        m = width;
        if (m < 1) m = 1;
        if (m > 32) m = 32;
        return m;
    endfunction

    function automatic int code_len(input logic [POS_W-1:0] width);
        int m;
        int r;
        m = eff_width(width);
        r = 0;
        while (r < 7 && (1 << r) < m + r + 1) r++;
        return m + r;
    endfunction

    // Encode places data at the non-power-of-two positions and fills in parity;
    // decode XORs the indices of the set positions to form the syndrome, then flips that position when it is within n.
    function automatic hsec_rsp_t hamming_outcome(input hsec_req_t item,
                                                  input logic [POS_W-1:0] width);
        hsec_rsp_t   res;
        logic [63:0] cw;
        int          n;
        int          k;
        int          pos;
        int          p;
        int          syn;
        logic        par;
        n   = code_len(width);
        cw  = '0;
        syn = 0;
        res.error_position = '0;
        res.status = ST_CLEAN;
        if (item.command == CMD_ENCODE)
        begin
            k = 0;
            for (pos = 1; pos <= n; pos++)
            begin
                if ((pos & (pos - 1)) != 0)
                begin
                    cw[pos - 1] = item.word_in[k];
                    k++;
                end
            end
            for (p = 0; (1 << p) <= n; p++)
            begin
                par = 1'b0;
                for (pos = 1; pos <= n; pos++)
                    if ((pos & (1 << p)) != 0) par ^= cw[pos - 1];
                cw[(1 << p) - 1] = par;
            end
        end
        else
        begin
            for (pos = 1; pos <= n; pos++)
            begin
                cw[pos - 1] = item.word_in[pos - 1];
                if (cw[pos - 1]) syn ^= pos;
            end
            res.error_position = syn[POS_W-1:0];
            if (syn != 0 && syn <= n)
            begin
                cw[syn - 1] = ~cw[syn - 1];
                res.status = ST_CORRECTED;
            end
            else if (syn != 0)
            begin
                res.status = ST_BEYOND;
            end
        end
        res.code_word = cw[WORD_W-1:0];
        return res;
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        return raw[WORD_W-1:0];
    endfunction

    // Mostly back to back, sometimes a short pause, now and then a long one.
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet_phase || roll < 70) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic queue_item(input logic cmd, input logic [WORD_W-1:0] word);
        hsec_req_t item;
        item.command = cmd;
        item.word_in = word;
        req_backlog.push_back(item);
    endtask

    // Decode beat built from a valid code word at the current width, with up
    // to two flipped positions (0 means none) and optional junk above n.
    task automatic queue_coded(input logic [WORD_W-1:0] data, input int flip_a,
                               input int flip_b, input bit junk);
        hsec_req_t item;
        hsec_rsp_t enc;
        int        n;
        item.command = CMD_ENCODE;
        item.word_in = data;
        enc = hamming_outcome(item, cur_width);
        n = code_len(cur_width);
        item.command = CMD_DECODE;
        item.word_in = enc.code_word;
        if (flip_a > 0) item.word_in[flip_a - 1] = ~item.word_in[flip_a - 1];
        if (flip_b > 0) item.word_in[flip_b - 1] = ~item.word_in[flip_b - 1];
        if (junk) item.word_in = item.word_in | (rand_word() << n);
        req_backlog.push_back(item);
    endtask

    // Sampled at the falling edge, after the driver has settled its beat.
    task automatic wait_idle();
        while (req_backlog.size() != 0 || req_valid || due_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_width(input logic [POS_W-1:0] width);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= width;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        cur_width = width;
    endtask

    // Driver: a new beat is offered only once the previous one was taken.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else
        begin
            if (req_valid && !req_stall)
                due_results.push_back(hamming_outcome(req, cur_width));
            if (!req_valid || !req_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_valid <= 1'b0;
                end
                else if (req_backlog.size() != 0)
                begin
                    req       <= req_backlog.pop_front();
                    req_valid <= 1'b1;
                    gap_left   = idle_len();
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted result beat and drives random stalls.
    always @(posedge clk)
    begin
        hsec_rsp_t want;
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result beat with no request outstanding: code_word %h", rsp.code_word);
                    fail_count++;
                end
                else
                begin
                    want = due_results.pop_front();
                    checked++;
                    if (want.status == ST_CORRECTED) corrected++;
                    if (want.status == ST_BEYOND) beyond++;
                    if (rsp.code_word !== want.code_word)
                    begin
                        $error("code_word expected %h actual %h", want.code_word, rsp.code_word);
                        fail_count++;
                    end
                    if (rsp.error_position !== want.error_position)
                    begin
                        $error("error_position expected %0d actual %0d",
                               want.error_position, rsp.error_position);
                        fail_count++;
                    end
                    if (rsp.status !== want.status)
                    begin
                        $error("status expected %0d actual %0d", want.status, rsp.status);
                        fail_count++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= 1'b0;
                stall_left = idle_len();
            end
        end
    end

    initial
    begin
        logic [POS_W-1:0]  widths[8];
        logic [WORD_W-1:0] data_mask;
        int                ph;
        int                k;
        int                n;
        int                roll;
        bit                junk;
        widths = '{6'd1, 6'd32, 6'd3, 6'd11, 6'd26, 6'd5, 6'd16, 6'd57};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Reset width of 4 bits: Hamming(7,4), including a double error.
        queue_item(CMD_ENCODE, '0);
        queue_item(CMD_ENCODE, '1);
        queue_coded(38'hA, 0, 0, 1'b0);
        queue_item(CMD_DECODE, '0);
        queue_item(CMD_DECODE, '1);
        queue_coded(38'h5, 1, 0, 1'b0);
        queue_coded(38'h5, 7, 0, 1'b1);
        queue_coded(38'h3, 2, 6, 1'b0);
        wait_idle();

        // Two data bits give n = 5, so syndromes 6 and 7 point past the word.
        write_width(6'd2);
        queue_item(CMD_DECODE, 38'h0A);
        queue_item(CMD_DECODE, 38'h12);
        queue_coded(38'h3, 5, 0, 1'b0);
        queue_item(CMD_ENCODE, 38'h3);
        wait_idle();

        // A width of zero behaves as one data bit.
        write_width(6'd0);
        queue_item(CMD_ENCODE, 38'h1);
        queue_item(CMD_DECODE, 38'h7);
        queue_coded(38'h1, 3, 0, 1'b0);
        wait_idle();

        // An oversized width saturates to 32 data bits and the full 38-bit word.
        write_width(6'd63);
        queue_item(CMD_ENCODE, '1);
        queue_coded('1, 38, 0, 1'b0);
        queue_coded('0, 32, 0, 1'b1);
        queue_item(CMD_DECODE, '1);
        wait_idle();

        for (ph = 0; ph < PHASES; ph++)
        begin
            write_width(ph < 8 ? widths[ph] : 6'($urandom_range(0, 63)));
            quiet_phase = (ph % 3 == 2);
            n = code_len(cur_width);
            data_mask = (38'd1 << eff_width(cur_width)) - 38'd1;
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                roll = $urandom_range(0, 99);
                junk = ($urandom_range(0, 3) == 0);
                if (roll < 35)
                    queue_item(CMD_ENCODE, junk ? rand_word() : rand_word() & data_mask);
                else if (roll < 55)
                    queue_coded(rand_word(), 0, 0, junk);
                else if (roll < 80)
                    queue_coded(rand_word(), $urandom_range(1, n), 0, junk);
                else if (roll < 92)
                    queue_coded(rand_word(), $urandom_range(1, n), $urandom_range(1, n), junk);
                else
                    queue_item(CMD_DECODE, rand_word());
            end
            wait_idle();
        end

        $display("Checked %0d encode/decode results over %0d data width settings,",
                 checked, PHASES + 4);
        $display("including %0d corrected words and %0d syndromes beyond the code length.",
                 corrected, beyond);
        if (fail_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    initial
    begin
        #15_000_000;
        $display("Timeout with %0d results still due", due_results.size());
        $display("tb NOT OK");
        $finish;
    end

endmodule
